// ----- src/wsg_pkg.sv -----
// ----------------------------------------------------------------------------
// wsg_pkg
// Constants, register indexes, waveform codes and the quarter-wave sine
// table shared by the waveform sample generator.
// ----------------------------------------------------------------------------
package wsg_pkg;

  // block constants
  localparam int SAMPLES        = 256;
  localparam int DAC_FULL_CODE  = 4095;
  localparam int REF_MILLIVOLTS = 3300;
  localparam int Q15_ONE        = 32767;

  // port widths
  localparam int IN_W       = 8;
  localparam int CODE_W     = 12;
  localparam int MV_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM_TYPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE_MV  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_BASED    = 2'd2;

  // waveform codes
  localparam logic [1:0] WAVE_SINE     = 2'd0;
  localparam logic [1:0] WAVE_SQUARE   = 2'd1;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd2;
  localparam logic [1:0] WAVE_SINE_ALT = 2'd3;

  // reset values
  localparam logic [1:0]      RST_WAVEFORM_TYPE = WAVE_SINE;
  localparam logic [MV_W-1:0] RST_PEAK_MV       = 16'd1650;
  localparam logic            RST_ZERO_BASED    = 1'b1;

  // derived sizes
  localparam int IDX_W     = $clog2(SAMPLES);
  localparam int HALF_N    = SAMPLES / 2;
  localparam int HN_W      = $clog2(HALF_N);
  localparam int FULL_W    = $clog2(DAC_FULL_CODE + 1);
  localparam int HALF_CODE = DAC_FULL_CODE / 2;
  localparam int MAX_MV    = REF_MILLIVOLTS / 2;
  localparam int AMP_W     = $clog2(HALF_CODE + 1);
  localparam int MVS_W     = $clog2(MAX_MV + 1);
  localparam int TRI_W     = FULL_W + HN_W;

  // phase: 16-bit word, upper byte is the table step, lower byte the fraction
  localparam int STEP_W   = 8;
  localparam int FRAC_W   = 8;
  localparam int PH_W     = STEP_W + FRAC_W;
  localparam int PH_SHIFT = PH_W - IDX_W;
  localparam int SINE_W   = 16;

  // amplitude scaling: amp = mv * HALF_CODE / MAX_MV by reciprocal
  localparam int AMP_NUM_W  = $clog2(MAX_MV * HALF_CODE + 1);
  localparam int AMP_S      = AMP_NUM_W;
  localparam int AMP_R      = (1 << AMP_S) / MAX_MV;
  localparam int AMP_R_W    = $clog2(AMP_R + 1);
  localparam int AMP_PROD_W = AMP_NUM_W + AMP_R_W;

  // sine scaling: code = num / (2 * Q15_ONE) by reciprocal
  localparam int NUM_W     = $clog2(longint'(2 * Q15_ONE) * longint'(DAC_FULL_CODE) + 1) + 1;
  localparam int MAG_W     = NUM_W - 1;
  localparam int DIV_D     = 2 * Q15_ONE;
  localparam int DIV_S     = MAG_W;
  localparam int DIV_R     = int'((longint'(1) << DIV_S) / DIV_D);
  localparam int DIV_R_W   = $clog2(DIV_R + 1);
  localparam int DIV_PROD_W = MAG_W + DIV_R_W;

  // sin(k*pi/128), k = 0..64, Q1.15
  localparam logic [15:0] QUARTER_SINE [0:64] = '{
    16'd0,     16'd804,   16'd1608,  16'd2410,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
    16'd6393,  16'd7179,  16'd7962,  16'd8739,  16'd9512,  16'd10278, 16'd11039, 16'd11793,
    16'd12539, 16'd13279, 16'd14010, 16'd14732, 16'd15446, 16'd16151, 16'd16846, 16'd17530,
    16'd18204, 16'd18868, 16'd19519, 16'd20159, 16'd20787, 16'd21403, 16'd22005, 16'd22594,
    16'd23170, 16'd23731, 16'd24279, 16'd24811, 16'd25329, 16'd25832, 16'd26319, 16'd26790,
    16'd27245, 16'd27683, 16'd28105, 16'd28510, 16'd28898, 16'd29268, 16'd29621, 16'd29956,
    16'd30273, 16'd30571, 16'd30852, 16'd31113, 16'd31356, 16'd31580, 16'd31785, 16'd31971,
    16'd32137, 16'd32285, 16'd32412, 16'd32521, 16'd32609, 16'd32678, 16'd32728, 16'd32757,
    16'd32767
  };

  // full-period sine from the quarter table, 256 steps per period
  function automatic logic signed [SINE_W-1:0] sine_at_step(input logic [STEP_W-1:0] step);
    logic [6:0] r;
    logic [6:0] mirror;
    r      = 7'(step[5:0]);
    mirror = 7'd64 - r;
    unique case (step[7:6])
      2'd0:    sine_at_step = QUARTER_SINE[r];
      2'd1:    sine_at_step = QUARTER_SINE[mirror];
      2'd2:    sine_at_step = -QUARTER_SINE[r];
      default: sine_at_step = -QUARTER_SINE[mirror];
    endcase
  endfunction

endpackage

// ----- src/waveform_sample_generator_top.sv -----
// ----------------------------------------------------------------------------
// waveform_sample_generator_top
// Sine, square or triangle DAC code for one sample index, nine-stage pipeline.
//
//   channel   signals                                  direction
//   input     in_valid, in_ready, sample_index[7:0]    item in
//   output    out_valid, out_ready, sample_value[11:0] item out
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data register write
//
// one item per cycle sustained while out_ready stays high; out_valid rises once an
// item has passed all nine register stages (amplitude scaling and the
// reciprocal divide by 65534 each take a multiply, a check multiply and a fix)
// each stage holds only while the stage after it is full and stalled, so
// bubbles close up and input stalls only once all nine stages hold items
// reset clears all valid bits and loads the register reset values
// ----------------------------------------------------------------------------
module waveform_sample_generator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [wsg_pkg::IN_W-1:0]        sample_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [wsg_pkg::CODE_W-1:0]      sample_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wsg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wsg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wsg_pkg::*;

  localparam int STAGES = 9;

  typedef struct packed {
    logic [IDX_W-1:0]             idx;
    logic [1:0]                   wtype;
    logic                         zb;
    logic [AMP_NUM_W-1:0]         amp_num;
    logic signed [SINE_W-1:0]     s0;
    logic signed [SINE_W-1:0]     s1;
    logic [FRAC_W-1:0]            frac;
    logic [AMP_W-1:0]             amp_est;
    logic [AMP_NUM_W-1:0]         amp_chk;
    logic [AMP_W-1:0]             amp;
    logic signed [SINE_W-1:0]     sine;
    logic [FULL_W-1:0]            hi;
    logic [FULL_W-1:0]            lo;
    logic [MAG_W-1:0]             num;
    logic [TRI_W-1:0]             tri_prod;
    logic [FULL_W-1:0]            code;
    logic [FULL_W-1:0]            q_est;
    logic [MAG_W-1:0]             q_chk;
  } item_t;

  // configuration registers
  logic [1:0]      waveform_type;
  logic [MV_W-1:0] amplitude_mv;
  logic            zero_based;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform_type <= RST_WAVEFORM_TYPE;
      amplitude_mv  <= RST_PEAK_MV;
      zero_based    <= RST_ZERO_BASED;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WAVEFORM_TYPE: waveform_type <= cfg_data[1:0];
        REG_AMPLITUDE_MV:  amplitude_mv  <= cfg_data[MV_W-1:0];
        REG_ZERO_BASED:    zero_based    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline
  item_t pipe      [1:STAGES];
  item_t pipe_next [1:STAGES];
  logic  v         [1:STAGES];
  logic  take      [1:STAGES];

  always_comb begin
    take[STAGES] = !v[STAGES] || out_ready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      take[k] = !v[k] || take[k+1];
    end
  end

  assign in_ready     = take[1];
  assign out_valid    = v[STAGES];
  assign sample_value = CODE_W'(pipe[STAGES].code);

  always_comb begin
    logic [MVS_W-1:0]         mv_sat;
    logic [PH_W-1:0]          ph;
    logic [AMP_PROD_W-1:0]    amp_prod;
    logic signed [SINE_W:0]   diff;
    logic signed [25:0]       iprod;
    logic signed [25:0]       iadj;
    logic [SINE_W:0]          isum;
    logic [AMP_NUM_W-1:0]     amp_rem;
    logic [AMP_W:0]           amp_c;
    logic [FULL_W:0]          wide;
    logic [SINE_W:0]          sh;
    logic [MAG_W-1:0]         n_zb;
    logic signed [NUM_W-1:0]  sx;
    logic signed [NUM_W-1:0]  ax;
    logic signed [NUM_W-1:0]  n_c;
    logic [DIV_PROD_W-1:0]    div_prod;
    logic [FULL_W-1:0]        tstep;
    logic                     rising;
    logic [MAG_W-1:0]         q_rem;
    logic [FULL_W:0]          q_c;

    // stage 1: sine table lookup, amplitude numerator
    pipe_next[1]       = '0;
    pipe_next[1].idx   = sample_index[IDX_W-1:0];
    pipe_next[1].wtype = waveform_type;
    pipe_next[1].zb    = zero_based;
    mv_sat = (amplitude_mv > MV_W'(MAX_MV)) ? MVS_W'(MAX_MV)
                                            : amplitude_mv[MVS_W-1:0];
    pipe_next[1].amp_num = AMP_NUM_W'(mv_sat) * AMP_NUM_W'(HALF_CODE);
    ph = PH_W'(pipe_next[1].idx) << PH_SHIFT;
    pipe_next[1].frac = ph[FRAC_W-1:0];
    pipe_next[1].s0   = sine_at_step(ph[PH_W-1:FRAC_W]);
    pipe_next[1].s1   = sine_at_step(STEP_W'(ph[PH_W-1:FRAC_W] + 8'd1));

    // stage 2: amplitude estimate, sine interpolation
    pipe_next[2] = pipe[1];
    amp_prod = AMP_PROD_W'(pipe[1].amp_num) * AMP_PROD_W'(AMP_R);
    pipe_next[2].amp_est = AMP_W'(amp_prod >> AMP_S);
    diff  = {pipe[1].s1[SINE_W-1], pipe[1].s1} - {pipe[1].s0[SINE_W-1], pipe[1].s0};
    iprod = diff * $signed({1'b0, pipe[1].frac});
    // truncate toward zero on the divide by 256
    iadj  = iprod + (iprod[25] ? 26'sd255 : 26'sd0);
    isum  = {pipe[1].s0[SINE_W-1], pipe[1].s0} + iadj[SINE_W+FRAC_W:FRAC_W];
    pipe_next[2].sine = isum[SINE_W-1:0];

    // stage 3: check multiply for the amplitude estimate
    pipe_next[3] = pipe[2];
    pipe_next[3].amp_chk = AMP_NUM_W'(pipe[2].amp_est) * AMP_NUM_W'(MAX_MV);

    // stage 4: amplitude correction and saturation
    pipe_next[4] = pipe[3];
    amp_rem = pipe[3].amp_num - pipe[3].amp_chk;
    amp_c   = (AMP_W+1)'(pipe[3].amp_est) + (AMP_W+1)'(amp_rem >= AMP_NUM_W'(MAX_MV));
    pipe_next[4].amp = (amp_c > (AMP_W+1)'(HALF_CODE)) ? AMP_W'(HALF_CODE) : amp_c[AMP_W-1:0];

    // stage 5: high and low levels
    pipe_next[5] = pipe[4];
    if (pipe[4].zb) begin
      wide = (FULL_W+1)'(pipe[4].amp) << 1;
      pipe_next[5].hi = (wide > (FULL_W+1)'(DAC_FULL_CODE)) ? FULL_W'(DAC_FULL_CODE)
                                                             : wide[FULL_W-1:0];
      pipe_next[5].lo = '0;
    end else begin
      wide = (FULL_W+1)'(HALF_CODE) + (FULL_W+1)'(pipe[4].amp);
      pipe_next[5].hi = (wide > (FULL_W+1)'(DAC_FULL_CODE)) ? FULL_W'(DAC_FULL_CODE)
                                                             : wide[FULL_W-1:0];
      pipe_next[5].lo = (pipe[4].amp > AMP_W'(HALF_CODE)) ? '0
                        : FULL_W'(HALF_CODE) - FULL_W'(pipe[4].amp);
    end

    // stage 6: sine numerator and triangle product
    pipe_next[6] = pipe[5];
    sh   = {pipe[5].sine[SINE_W-1], pipe[5].sine} + (SINE_W+1)'(Q15_ONE);
    n_zb = MAG_W'(sh) * MAG_W'(pipe[5].hi);
    sx   = NUM_W'(pipe[5].sine);
    ax   = NUM_W'(pipe[5].amp);
    n_c  = ((sx * ax) <<< 1) + NUM_W'(longint'(DAC_FULL_CODE) * longint'(Q15_ONE));
    if (pipe[5].zb) begin
      pipe_next[6].num = n_zb;
    end else begin
      // a negative numerator maps to code zero
      pipe_next[6].num = n_c[NUM_W-1] ? '0 : n_c[MAG_W-1:0];
    end
    // both halves have power-of-two length, so the offset is the low bits
    pipe_next[6].tri_prod = TRI_W'(pipe[5].hi - pipe[5].lo) * TRI_W'(pipe[5].idx[HN_W-1:0]);

    // stage 7: quotient estimate, square and triangle codes
    pipe_next[7] = pipe[6];
    div_prod = DIV_PROD_W'(pipe[6].num) * DIV_PROD_W'(DIV_R);
    pipe_next[7].q_est = FULL_W'(div_prod >> DIV_S);
    tstep  = FULL_W'(pipe[6].tri_prod >> HN_W);
    rising = pipe[6].idx < IDX_W'(HALF_N);
    unique case (pipe[6].wtype)
      WAVE_SQUARE: begin
        pipe_next[7].code = rising ? pipe[6].hi : pipe[6].lo;
      end
      WAVE_TRIANGLE: begin
        pipe_next[7].code = rising ? pipe[6].lo + tstep : pipe[6].hi - tstep;
        // first, middle and last points are pinned
        if (pipe[6].idx == '0)                  pipe_next[7].code = pipe[6].lo;
        if (pipe[6].idx == IDX_W'(HALF_N - 1))  pipe_next[7].code = pipe[6].hi;
        if (pipe[6].idx == IDX_W'(SAMPLES - 1)) pipe_next[7].code = pipe[6].lo;
      end
      WAVE_SINE, WAVE_SINE_ALT: begin
        pipe_next[7].code = '0;
      end
    endcase

    // stage 8: check multiply for the quotient
    pipe_next[8] = pipe[7];
    pipe_next[8].q_chk = MAG_W'(pipe[7].q_est) * MAG_W'(DIV_D);

    // stage 9: quotient correction and clamp, output register
    pipe_next[9] = pipe[8];
    q_rem = pipe[8].num - pipe[8].q_chk;
    q_c   = (FULL_W+1)'(pipe[8].q_est) + (FULL_W+1)'(q_rem >= MAG_W'(DIV_D));
    if (pipe[8].wtype != WAVE_SQUARE && pipe[8].wtype != WAVE_TRIANGLE) begin
      pipe_next[9].code = (q_c > (FULL_W+1)'(DAC_FULL_CODE)) ? FULL_W'(DAC_FULL_CODE)
                                                             : q_c[FULL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= STAGES; k++) begin
        v[k] <= 1'b0;
      end
    end else begin
      if (take[1]) v[1] <= in_valid;
      for (int k = 2; k <= STAGES; k++) begin
        if (take[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= STAGES; k++) begin
      if (take[k]) pipe[k] <= pipe_next[k];
    end
  end

  // reciprocal estimates are never more than one short
  a_amp_est_close: assert property (@(posedge clk) disable iff (rst)
    v[3] |-> (pipe[3].amp_num - pipe[3].amp_chk) < AMP_NUM_W'(2 * MAX_MV))
    else $error("amplitude estimate off by more than one");

  a_div_est_close: assert property (@(posedge clk) disable iff (rst)
    v[8] |-> (pipe[8].num - pipe[8].q_chk) < MAG_W'(2 * DIV_D))
    else $error("sine quotient estimate off by more than one");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (v[1] && v[2] && v[3] && v[4] && v[5] && v[6] && v[7] && v[8] && v[9] && !out_ready)
      |-> !in_ready)
    else $error("input taken while every stage is full and stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule
